>>> rtl/fdtd_pkg.sv
// Package for the 1D field update unit: word types, sizes and codes.
// Used by fdtd_1d_field_update_unit; depends on nothing.
package fdtd_pkg;

  localparam int MAX_CELLS = 1024;
  localparam int ADDR_W = $clog2(MAX_CELLS);
  localparam int CNT_W = ADDR_W + 1;
  localparam int PADDR_W = 5;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_STEP = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  localparam logic [2:0] REG_ACTIVE = 3'd0;
  localparam logic [2:0] REG_SOURCE = 3'd1;
  localparam logic [2:0] REG_BCOEF = 3'd2;
  localparam logic [2:0] REG_LEFT = 3'd3;
  localparam logic [2:0] REG_RIGHT = 3'd4;

  typedef enum logic [2:0] {
    OP_HSWEEP = 3'd0,
    OP_HSRC = 3'd1,
    OP_ESWEEP = 3'd2,
    OP_MURL = 3'd3,
    OP_MURR = 3'd4,
    OP_ESRC = 3'd5
  } op_t;

  typedef struct packed {
    logic [1:0] command;
    logic [9:0] cell_index;
    logic [30:0] e_coef_value;
    logic [30:0] h_coef_value;
    logic signed [31:0] source_h;
    logic signed [31:0] source_e;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] left_probe;
    logic signed [31:0] right_probe;
    logic signed [31:0] read_e;
    logic signed [31:0] read_h;
  } out_word_t;

endpackage

>>> rtl/fdtd_1d_field_update_unit.sv
// Top level of the 1D field update unit: field and coefficient memories,
// sequencer and one shared multiplier. Depends on fdtd_pkg.
//
// After reset the unit clears both field memories, one cell per cycle, and
// stays busy meanwhile. A load, read or unused command passes through the
// result states P1, P2 and P3 before the done strobe. In a time step every
// cell of the H and E sweeps takes a read, a multiply and a write-back step
// on the single shared multiplier, and so do the H and E source fixes and
// each absorbing edge fix that is on; a priming step before each sweep and
// the three result states complete it. The result word is shown for one
// cycle with done high and cannot be held off.
module fdtd_1d_field_update_unit (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  fdtd_pkg::in_word_t request,
  output logic done,
  output fdtd_pkg::out_word_t result,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [fdtd_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CLEAR = 9'b000000010,
    S_PRIME = 9'b000000100,
    S_RD    = 9'b000001000,
    S_MUL   = 9'b000010000,
    S_WB    = 9'b000100000,
    S_P1    = 9'b001000000,
    S_P2    = 9'b010000000,
    S_P3    = 9'b100000000
  } state_t;

  localparam int AW = fdtd_pkg::ADDR_W;

  state_t state;
  fdtd_pkg::op_t op;

  logic [fdtd_pkg::CNT_W-1:0] active_cells;
  logic [9:0] source_cell;
  logic signed [23:0] boundary_coef;
  logic left_absorb_on;
  logic right_absorb_on;

  logic signed [31:0] e_mem [fdtd_pkg::MAX_CELLS];
  logic signed [31:0] h_mem [fdtd_pkg::MAX_CELLS];
  logic [30:0] ce_mem [fdtd_pkg::MAX_CELLS];
  logic [30:0] ch_mem [fdtd_pkg::MAX_CELLS];

  logic signed [31:0] rd_e;
  logic signed [31:0] rd_h;
  logic [30:0] rd_ce;
  logic [30:0] rd_ch;

  logic [AW-1:0] e_raddr;
  logic [AW-1:0] h_raddr;
  logic [AW-1:0] c_raddr;
  logic e_we;
  logic h_we;
  logic c_we;
  logic [AW-1:0] w_addr;
  logic signed [31:0] w_data;

  logic [AW-1:0] idx;
  logic [AW-1:0] wb_addr;
  logic [AW-1:0] clr_cnt;
  logic [1:0] cmd;
  logic [9:0] cell_sel;
  logic signed [31:0] src_h;
  logic signed [31:0] src_e;
  logic signed [31:0] e_prev;
  logic signed [31:0] h_prev;
  logic signed [31:0] old_l;
  logic signed [31:0] old_r;
  logic signed [31:0] new_l;
  logic signed [31:0] new_r;
  logic signed [31:0] base;
  logic signed [65:0] prod;

  logic signed [33:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [31:0] mul_base;
  logic signed [65:0] rnd;
  logic signed [44:0] term;
  logic signed [44:0] sum;
  logic signed [31:0] sum_sat;

  logic [fdtd_pkg::CNT_W-1:0] n_cells;
  logic [AW-1:0] n_last;
  logic [AW-1:0] n_m2;
  logic [AW-1:0] s_cell;
  logic cfg_wr;

  always_comb begin
    if (active_cells < fdtd_pkg::CNT_W'(4)) begin
      n_cells = fdtd_pkg::CNT_W'(4);
    end else if (active_cells > fdtd_pkg::CNT_W'(fdtd_pkg::MAX_CELLS)) begin
      n_cells = fdtd_pkg::CNT_W'(fdtd_pkg::MAX_CELLS);
    end else begin
      n_cells = active_cells;
    end
    n_last = AW'(n_cells - fdtd_pkg::CNT_W'(1));
    n_m2 = AW'(n_cells - fdtd_pkg::CNT_W'(2));
    if (source_cell < 10'd1) begin
      s_cell = AW'(1);
    end else if (AW'(source_cell) > n_m2) begin
      s_cell = n_m2;
    end else begin
      s_cell = AW'(source_cell);
    end
  end

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_cells <= fdtd_pkg::CNT_W'(1024);
      source_cell <= 10'd30;
      boundary_coef <= '0;
      left_absorb_on <= 1'b1;
      right_absorb_on <= 1'b1;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        fdtd_pkg::REG_ACTIVE: active_cells <= pwdata[10:0];
        fdtd_pkg::REG_SOURCE: source_cell <= pwdata[9:0];
        fdtd_pkg::REG_BCOEF: boundary_coef <= pwdata[23:0];
        fdtd_pkg::REG_LEFT: left_absorb_on <= pwdata[0];
        fdtd_pkg::REG_RIGHT: right_absorb_on <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      fdtd_pkg::REG_ACTIVE: prdata = 32'(active_cells);
      fdtd_pkg::REG_SOURCE: prdata = 32'(source_cell);
      fdtd_pkg::REG_BCOEF: prdata = {{8{boundary_coef[23]}}, boundary_coef};
      fdtd_pkg::REG_LEFT: prdata = 32'(left_absorb_on);
      fdtd_pkg::REG_RIGHT: prdata = 32'(right_absorb_on);
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (e_we) begin
      e_mem[w_addr] <= w_data;
    end
    if (h_we) begin
      h_mem[w_addr] <= w_data;
    end
    if (c_we) begin
      ce_mem[w_addr] <= request.e_coef_value;
      ch_mem[w_addr] <= request.h_coef_value;
    end
    rd_e <= e_mem[e_raddr];
    rd_h <= h_mem[h_raddr];
    rd_ce <= ce_mem[c_raddr];
    rd_ch <= ch_mem[c_raddr];
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    mul_base = '0;
    unique case (op)
      fdtd_pkg::OP_HSWEEP: begin
        mul_a = {{2{rd_e[31]}}, rd_e} - {{2{e_prev[31]}}, e_prev};
        mul_b = {1'b0, rd_ch};
        mul_base = rd_h;
      end
      fdtd_pkg::OP_HSRC: begin
        mul_a = {{2{src_h[31]}}, src_h};
        mul_b = {1'b0, rd_ch};
        mul_base = rd_h;
      end
      fdtd_pkg::OP_ESWEEP: begin
        mul_a = {{2{rd_h[31]}}, rd_h} - {{2{h_prev[31]}}, h_prev};
        mul_b = {1'b0, rd_ce};
        mul_base = rd_e;
      end
      fdtd_pkg::OP_MURL: begin
        mul_a = {{2{new_l[31]}}, new_l} - {{2{rd_e[31]}}, rd_e};
        mul_b = {{8{boundary_coef[23]}}, boundary_coef};
        mul_base = old_l;
      end
      fdtd_pkg::OP_MURR: begin
        mul_a = {{2{new_r[31]}}, new_r} - {{2{rd_e[31]}}, rd_e};
        mul_b = {{8{boundary_coef[23]}}, boundary_coef};
        mul_base = old_r;
      end
      fdtd_pkg::OP_ESRC: begin
        mul_a = {{2{src_e[31]}}, src_e};
        mul_b = {1'b0, rd_ce};
        mul_base = rd_e;
      end
      default: ;
    endcase
  end

  // The H source term is rounded before it is subtracted.
  always_comb begin
    rnd = prod + 66'sd2097152;
    term = {rnd[65], rnd[65:22]};
    if (op == fdtd_pkg::OP_HSRC) begin
      sum = {{13{base[31]}}, base} - term;
    end else begin
      sum = {{13{base[31]}}, base} + term;
    end
    if (sum[44:31] == {14{sum[44]}}) begin
      sum_sat = sum[31:0];
    end else if (sum[44]) begin
      sum_sat = 32'sh80000000;
    end else begin
      sum_sat = 32'sh7fffffff;
    end
  end

  always_comb begin
    e_raddr = '0;
    h_raddr = '0;
    c_raddr = '0;
    e_we = 1'b0;
    h_we = 1'b0;
    c_we = 1'b0;
    w_addr = wb_addr;
    w_data = sum_sat;
    unique case (state)
      S_IDLE: begin
        e_raddr = AW'(request.cell_index);
        h_raddr = AW'(request.cell_index);
        w_addr = AW'(request.cell_index);
        c_we = start && (request.command == fdtd_pkg::CMD_LOAD);
      end
      S_CLEAR: begin
        w_addr = clr_cnt;
        w_data = '0;
        e_we = 1'b1;
        h_we = 1'b1;
      end
      S_PRIME: begin
        e_raddr = '0;
        h_raddr = '0;
      end
      S_RD: begin
        unique case (op)
          fdtd_pkg::OP_HSWEEP: begin
            e_raddr = idx + AW'(1);
            h_raddr = idx;
            c_raddr = idx;
          end
          fdtd_pkg::OP_HSRC: begin
            h_raddr = s_cell - AW'(1);
            c_raddr = s_cell - AW'(1);
          end
          fdtd_pkg::OP_ESWEEP: begin
            e_raddr = idx;
            h_raddr = idx;
            c_raddr = idx;
          end
          fdtd_pkg::OP_MURL: e_raddr = '0;
          fdtd_pkg::OP_MURR: e_raddr = n_last;
          fdtd_pkg::OP_ESRC: begin
            e_raddr = s_cell;
            c_raddr = s_cell;
          end
          default: ;
        endcase
      end
      S_WB: begin
        h_we = (op == fdtd_pkg::OP_HSWEEP) || (op == fdtd_pkg::OP_HSRC);
        e_we = !h_we;
      end
      S_P1: e_raddr = AW'(1);
      S_P2: e_raddr = n_m2;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      op <= fdtd_pkg::OP_HSWEEP;
      clr_cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == {AW{1'b1}}) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            if (request.command == fdtd_pkg::CMD_STEP) begin
              op <= fdtd_pkg::OP_HSWEEP;
              state <= S_PRIME;
            end else begin
              state <= S_P1;
            end
          end
        end
        S_PRIME: state <= S_RD;
        S_RD: state <= S_MUL;
        S_MUL: state <= S_WB;
        S_WB: begin
          state <= S_RD;
          unique case (op)
            fdtd_pkg::OP_HSWEEP: begin
              if (idx == n_m2) begin
                op <= fdtd_pkg::OP_HSRC;
              end
            end
            fdtd_pkg::OP_HSRC: begin
              op <= fdtd_pkg::OP_ESWEEP;
              state <= S_PRIME;
            end
            fdtd_pkg::OP_ESWEEP: begin
              if (idx == n_m2) begin
                if (left_absorb_on) begin
                  op <= fdtd_pkg::OP_MURL;
                end else if (right_absorb_on) begin
                  op <= fdtd_pkg::OP_MURR;
                end else begin
                  op <= fdtd_pkg::OP_ESRC;
                end
              end
            end
            fdtd_pkg::OP_MURL: begin
              op <= right_absorb_on ? fdtd_pkg::OP_MURR : fdtd_pkg::OP_ESRC;
            end
            fdtd_pkg::OP_MURR: op <= fdtd_pkg::OP_ESRC;
            fdtd_pkg::OP_ESRC: state <= S_P1;
            default: ;
          endcase
        end
        S_P1: state <= S_P2;
        S_P2: state <= S_P3;
        S_P3: begin
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      cmd <= request.command;
      cell_sel <= request.cell_index;
      src_h <= request.source_h;
      src_e <= request.source_e;
      idx <= '0;
    end
    if (state == S_RD) begin
      if (op == fdtd_pkg::OP_HSWEEP && idx == '0) begin
        e_prev <= rd_e;
      end
      if (op == fdtd_pkg::OP_ESWEEP && idx == AW'(1)) begin
        h_prev <= rd_h;
      end
      unique case (op)
        fdtd_pkg::OP_HSRC: wb_addr <= s_cell - AW'(1);
        fdtd_pkg::OP_MURL: wb_addr <= '0;
        fdtd_pkg::OP_MURR: wb_addr <= n_last;
        fdtd_pkg::OP_ESRC: wb_addr <= s_cell;
        default: wb_addr <= idx;
      endcase
    end
    if (state == S_MUL) begin
      prod <= 66'(mul_a) * 66'(mul_b);
      base <= mul_base;
      if (op == fdtd_pkg::OP_HSWEEP) begin
        e_prev <= rd_e;
      end
      if (op == fdtd_pkg::OP_ESWEEP) begin
        h_prev <= rd_h;
        if (idx == AW'(1)) begin
          old_l <= rd_e;
        end
        if (idx == n_m2) begin
          old_r <= rd_e;
        end
      end
    end
    if (state == S_WB) begin
      if (op == fdtd_pkg::OP_ESWEEP) begin
        if (idx == AW'(1)) begin
          new_l <= sum_sat;
        end
        if (idx == n_m2) begin
          new_r <= sum_sat;
        end
      end
      if ((op == fdtd_pkg::OP_HSWEEP || op == fdtd_pkg::OP_ESWEEP) && idx != n_m2) begin
        idx <= idx + AW'(1);
      end else if (op == fdtd_pkg::OP_HSRC) begin
        idx <= AW'(1);
      end
    end
    if (state == S_P1) begin
      if (cmd == fdtd_pkg::CMD_READ) begin
        result.read_e <= rd_e;
        result.read_h <= rd_h;
      end else begin
        result.read_e <= '0;
        result.read_h <= '0;
      end
    end
    if (state == S_P2) begin
      result.left_probe <= rd_e;
    end
    if (state == S_P3) begin
      result.right_probe <= rd_e;
    end
  end

  assign busy = (state != S_IDLE);

`ifndef SYNTH
  a_done_after_p3: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_P3))
    else $error("done without finishing sequence");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not make the unit busy");

  a_wb_after_mul: assert property (@(posedge clk) disable iff (rst)
    (state == S_WB) |-> $past(state == S_MUL))
    else $error("write-back without a product");

  a_cell_name: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && start) |=> (cell_sel == $past(request.cell_index)))
    else $error("cell index not captured");
`endif

endmodule
